// ----- sv/aisr_pkg.sv -----
`default_nettype none

package aisr_pkg;

  // Width of the root result.
  localparam int unsigned ROOT_BITS = 16;

endpackage

`default_nettype wire

// ----- sv/approx_integer_square_root.sv -----
`default_nettype none

// Approximate integer square root, one Newton step from a power-of-two seed.
//
// Input: drive radicand and raise start for one cycle; the beat is taken at
// any edge where start is high and busy is low. busy is high only while rst
// is high, so outside reset a new radicand can be issued every cycle.
// Output: done pulses for one cycle with root valid in that same cycle. The
// receiver cannot stall; each root must be captured when done is high.
// Path: an accepted beat passes through the input register, bit-length
// detect, shift and add-and-halve stages in that order, and done and root
// are registered by the last. Throughput: one beat per cycle, set by the
// four-stage pipeline with no shared unit.
// A zero radicand gives a zero root. For INPUT_BITS above 32 the root holds
// the low 16 bits of the estimate.
// Reset (rst, synchronous, active high) clears every stage's valid bit, so
// beats in flight are dropped and done stays low until a new beat arrives.
module approx_integer_square_root #(
  parameter int unsigned INPUT_BITS = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [INPUT_BITS-1:0]         radicand,
  output logic                               done,
  output logic [aisr_pkg::ROOT_BITS-1:0]     root
);

  localparam int unsigned LenBits = $clog2(INPUT_BITS + 1);

  logic                  in_valid;
  logic [INPUT_BITS-1:0] in_value;
  logic                  lzd_valid;
  logic [INPUT_BITS-1:0] lzd_value;
  logic [LenBits-1:0]    lzd_shamt;
  logic                  shift_valid;
  logic [INPUT_BITS-1:0] shift_quot;
  logic [INPUT_BITS-1:0] shift_est;

  // Refuse beats while reset clears the pipeline.
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_value <= radicand;
  end

  aisr_lzd #(
    .INPUT_BITS (INPUT_BITS),
    .LenBits    (LenBits)
  ) u_lzd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_value  (in_value),
    .out_valid (lzd_valid),
    .out_value (lzd_value),
    .out_shamt (lzd_shamt)
  );

  aisr_shift #(
    .INPUT_BITS (INPUT_BITS),
    .LenBits    (LenBits)
  ) u_shift (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lzd_valid),
    .in_value  (lzd_value),
    .in_shamt  (lzd_shamt),
    .out_valid (shift_valid),
    .out_quot  (shift_quot),
    .out_est   (shift_est)
  );

  aisr_avg #(
    .INPUT_BITS (INPUT_BITS)
  ) u_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (shift_valid),
    .in_quot   (shift_quot),
    .in_est    (shift_est),
    .out_valid (done),
    .out_root  (root)
  );

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted beat did not produce done after four cycles");

  a_zero_root : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && radicand == '0) |-> ##4 (root == '0))
    else $error("zero radicand gave a nonzero root");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    (!in_valid && !lzd_valid && !shift_valid) |=> !done)
    else $error("done raised with empty pipeline");
`endif

endmodule

`default_nettype wire

// ----- sv/aisr_lzd.sv -----
`default_nettype none

module aisr_lzd #(
  parameter int unsigned INPUT_BITS = 31,
  parameter int unsigned LenBits    = $clog2(INPUT_BITS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [INPUT_BITS-1:0] in_value,
  output logic                       out_valid,
  output logic [INPUT_BITS-1:0]      out_value,
  output logic [LenBits-1:0]         out_shamt
);

  logic [LenBits-1:0] bit_len;

  // Highest set bit wins; zero gives length zero.
  always_comb begin
    bit_len = '0;
    for (int i = 0; i < INPUT_BITS; i++) begin
      if (in_value[i]) begin
        bit_len = LenBits'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value <= in_value;
    out_shamt <= bit_len >> 1;
  end

endmodule

`default_nettype wire

// ----- sv/aisr_shift.sv -----
`default_nettype none

module aisr_shift #(
  parameter int unsigned INPUT_BITS = 31,
  parameter int unsigned LenBits    = $clog2(INPUT_BITS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [INPUT_BITS-1:0] in_value,
  input  wire logic [LenBits-1:0]    in_shamt,
  output logic                       out_valid,
  output logic [INPUT_BITS-1:0]      out_quot,
  output logic [INPUT_BITS-1:0]      out_est
);

  localparam logic [INPUT_BITS-1:0] One = INPUT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Estimate is a power of two, so the divide is a right shift.
  always_ff @(posedge clk) begin
    out_quot <= in_value >> in_shamt;
    out_est  <= One << in_shamt;
  end

endmodule

`default_nettype wire

// ----- sv/aisr_avg.sv -----
`default_nettype none

module aisr_avg #(
  parameter int unsigned INPUT_BITS = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [INPUT_BITS-1:0]         in_quot,
  input  wire logic [INPUT_BITS-1:0]         in_est,
  output logic                               out_valid,
  output logic [aisr_pkg::ROOT_BITS-1:0]     out_root
);

  localparam int unsigned SumBits =
    (INPUT_BITS + 1 > aisr_pkg::ROOT_BITS + 1) ? INPUT_BITS + 1 : aisr_pkg::ROOT_BITS + 1;

  logic [SumBits-1:0] sum;

  assign sum = SumBits'(in_quot) + SumBits'(in_est);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Halve and keep the low root bits.
  always_ff @(posedge clk) begin
    out_root <= sum[aisr_pkg::ROOT_BITS:1];
  end

endmodule

`default_nettype wire
